FILE: sv/efti_pkg.sv
// ----------------------------------------------------------------------------
// efti_pkg: shared types and constants
// Fixed-point widths, register indexes and the slot record of the loop.
// ----------------------------------------------------------------------------
package efti_pkg;

	localparam int unsigned FracBits = 28;
	localparam int unsigned CoordW   = 32;
	localparam int unsigned CountW   = 8;
	localparam int unsigned IndexW   = 8;
	localparam int unsigned DataW    = 32;
	localparam int unsigned TagW     = 2;

	localparam logic [63:0] EscapeMag2 = 64'd4 << (2 * FracBits);

	localparam logic [IndexW-1:0] RegFractalMode   = 8'd0;
	localparam logic [IndexW-1:0] RegJuliaCReal    = 8'd1;
	localparam logic [IndexW-1:0] RegJuliaCImag    = 8'd2;
	localparam logic [IndexW-1:0] RegIterationLimit = 8'd3;

	localparam logic [CountW-1:0] LimitReset = 8'd255;

	typedef struct packed {
		logic                     valid;
		logic                     done;
		logic [TagW-1:0]          tag;
		logic [CountW-1:0]        count;
		logic signed [CoordW-1:0] zr;
		logic signed [CoordW-1:0] zi;
		logic signed [CoordW-1:0] cr;
		logic signed [CoordW-1:0] ci;
	} slot_t;

endpackage

FILE: sv/efti_if.sv
// ----------------------------------------------------------------------------
// efti channel interfaces
// Point, result and register-write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface efti_point_if;
	logic                               valid;
	logic                               ready;
	logic signed [efti_pkg::CoordW-1:0] point_real;
	logic signed [efti_pkg::CoordW-1:0] point_imag;
	modport source (output valid, output point_real, output point_imag, input ready);
	modport sink (input valid, input point_real, input point_imag, output ready);
endinterface

interface efti_result_if;
	logic                        valid;
	logic                        ready;
	logic [efti_pkg::CountW-1:0] escape_count;
	modport source (output valid, output escape_count, input ready);
	modport sink (input valid, input escape_count, output ready);
endinterface

interface efti_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [efti_pkg::IndexW-1:0] index;
	logic [efti_pkg::DataW-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/escape_time_fractal_iteration.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_iteration: escape-time count for one complex point
// Iterates z = z*z + c in Q4.28 on a four-stage loop shared by four points.
// ----------------------------------------------------------------------------
//  channel  direction  transfer carries
//  pnt      in         point_real, point_imag
//  res      out        escape_count
//  cfg      in         index, data (register write)
//
// Each point makes one iteration per pass around the loop, slot_s1 to slot_s4.
// Up to four points circulate at once and results leave in arrival order.
// Reset clears the loop, the output valid flag and the registers to defaults.
// A stalled result keeps circulating in the loop without losing its count.
module escape_time_fractal_iteration (
	input  logic           clk,
	input  logic           arst_n,
	efti_point_if.sink     pnt,
	efti_result_if.source  res,
	efti_cfg_if.sink       cfg
);

	logic                               mode_q;
	logic signed [efti_pkg::CoordW-1:0] jcr_q;
	logic signed [efti_pkg::CoordW-1:0] jci_q;
	logic [efti_pkg::CountW-1:0]        limit_q;

	efti_pkg::slot_t slot_s1, slot_s2, slot_s3, slot_s4, entry, fresh, nxt_s2, nxt_s4;
	logic signed [63:0] rr_s1, ii_s1, ri_s1, mr_s3, mi_s3;
	logic [efti_pkg::TagW-1:0]   in_seq_q, out_seq_q;
	logic                        out_valid_q;
	logic [efti_pkg::CountW-1:0] out_count_q;

	logic exit_ok, take;
	logic signed [63:0] diff;
	logic signed [36:0] nr, ni;
	logic signed [efti_pkg::CoordW-1:0] zr_new, zi_new;
	logic [63:0] mag;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			jcr_q   <= '0;
			jci_q   <= '0;
			limit_q <= efti_pkg::LimitReset;
		end else if (cfg.valid) begin
			case (cfg.index)
				efti_pkg::RegFractalMode:    mode_q  <= cfg.data[0];
				efti_pkg::RegJuliaCReal:     jcr_q   <= cfg.data;
				efti_pkg::RegJuliaCImag:     jci_q   <= cfg.data;
				efti_pkg::RegIterationLimit: limit_q <= cfg.data[efti_pkg::CountW-1:0];
				default: ;
			endcase
		end
	end

	assign exit_ok = slot_s4.valid && slot_s4.done && (slot_s4.tag == out_seq_q)
		&& (!out_valid_q || res.ready);
	assign pnt.ready = !slot_s4.valid || exit_ok;
	assign take = pnt.valid && pnt.ready;

	always_comb begin
		fresh       = '0;
		fresh.valid = 1'b1;
		fresh.done  = (limit_q == '0);
		fresh.tag   = in_seq_q;
		fresh.count = '0;
		fresh.zr    = pnt.point_real;
		fresh.zi    = pnt.point_imag;
		fresh.cr    = mode_q ? jcr_q : pnt.point_real;
		fresh.ci    = mode_q ? jci_q : pnt.point_imag;
		if (take) begin
			entry = fresh;
		end else if (exit_ok) begin
			entry = '0;
		end else begin
			entry = slot_s4;
		end
	end

	always_comb begin
		diff = rr_s1 - ii_s1;
		nr = 37'(diff >>> efti_pkg::FracBits) + 37'(slot_s1.cr);
		ni = 37'(ri_s1 >>> (efti_pkg::FracBits - 1)) + 37'(slot_s1.ci);
		if (nr > 37'sd2147483647) begin
			zr_new = 32'sh7FFFFFFF;
		end else if (nr < -37'sd2147483648) begin
			zr_new = 32'sh80000000;
		end else begin
			zr_new = nr[31:0];
		end
		if (ni > 37'sd2147483647) begin
			zi_new = 32'sh7FFFFFFF;
		end else if (ni < -37'sd2147483648) begin
			zi_new = 32'sh80000000;
		end else begin
			zi_new = ni[31:0];
		end
		nxt_s2 = slot_s1;
		if (slot_s1.valid && !slot_s1.done) begin
			nxt_s2.zr = zr_new;
			nxt_s2.zi = zi_new;
		end
	end

	always_comb begin
		mag    = 64'(unsigned'(mr_s3)) + 64'(unsigned'(mi_s3));
		nxt_s4 = slot_s3;
		if (slot_s3.valid && !slot_s3.done) begin
			if (mag > efti_pkg::EscapeMag2) begin
				nxt_s4.done = 1'b1;
			end else begin
				nxt_s4.count = slot_s3.count + 8'd1;
				nxt_s4.done  = (slot_s3.count + 8'd1 == limit_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_s1     <= '0;
			slot_s2     <= '0;
			slot_s3     <= '0;
			slot_s4     <= '0;
			in_seq_q    <= '0;
			out_seq_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			slot_s1 <= entry;
			slot_s2 <= nxt_s2;
			slot_s3 <= slot_s2;
			slot_s4 <= nxt_s4;
			if (take) begin
				in_seq_q <= in_seq_q + 2'd1;
			end
			if (exit_ok) begin
				out_seq_q   <= out_seq_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rr_s1 <= 64'(entry.zr) * 64'(entry.zr);
		ii_s1 <= 64'(entry.zi) * 64'(entry.zi);
		ri_s1 <= 64'(entry.zr) * 64'(entry.zi);
		mr_s3 <= 64'(slot_s2.zr) * 64'(slot_s2.zr);
		mi_s3 <= 64'(slot_s2.zi) * 64'(slot_s2.zi);
		if (exit_ok) begin
			out_count_q <= slot_s4.count;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.escape_count = out_count_q;

endmodule

FILE: sim/efti_tb_if.sv
// ----------------------------------------------------------------------------
// Testbench channel note
// The block's own channel interfaces are reused unchanged by the testbench.
// ----------------------------------------------------------------------------
package efti_tb_pkg;

	typedef struct {
		logic signed [31:0] re;
		logic signed [31:0] im;
	} point_t;

endpackage

FILE: sim/escape_time_fractal_iteration_test.sv
// ----------------------------------------------------------------------------
// Escape-time fractal iteration testbench
// Drives points and register writes through the valid/ready channels, predicts
// each escape count with a fixed-point model of its own and compares every
// result transfer in order, under several idling patterns and a long stall.
// ----------------------------------------------------------------------------
module escape_time_fractal_iteration_test;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	efti_point_if  pnt();
	efti_result_if res();
	efti_cfg_if    cfg();

	escape_time_fractal_iteration DUT (
		.clk(clk), .arst_n(arst_n), .pnt(pnt.sink), .res(res.source), .cfg(cfg.sink)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [7:0]         mdl_mode;
	logic signed [31:0] mdl_cr;
	logic signed [31:0] mdl_ci;
	logic [7:0]         mdl_limit;

	logic [7:0] expected_counts[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_off = 0;
	int quiet_cycles = 0;
	localparam int QuietLimit = 200000;
	localparam int HoldCycles = 3000;

	function automatic logic signed [31:0] clamp32(logic signed [65:0] x);
		if (x > 66'sd2147483647) return 32'sh7fffffff;
		if (x < -66'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

	function automatic logic [7:0] escape_count_of(efti_tb_pkg::point_t p);
		logic signed [31:0] zr, zi, cr, ci;
		logic signed [65:0] rr, ii, ri, nr, ni;
		logic [65:0] mag;
		int n;
		zr = p.re;
		zi = p.im;
		cr = mdl_mode[0] ? mdl_cr : p.re;
		ci = mdl_mode[0] ? mdl_ci : p.im;
		n = 0;
		while (n < mdl_limit) begin
			rr = 66'(zr) * 66'(zr);
			ii = 66'(zi) * 66'(zi);
			ri = 66'(zr) * 66'(zi);
			nr = ((rr - ii) >>> 28) + 66'(cr);
			ni = (ri >>> 27) + 66'(ci);
			zr = clamp32(nr);
			zi = clamp32(ni);
			mag = 66'(66'(zr) * 66'(zr)) + 66'(66'(zi) * 66'(zi));
			if (mag > 66'(efti_pkg::EscapeMag2)) break;
			n++;
		end
		return n[7:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_off <= HoldCycles - 1;
			res.ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			if (expected_counts.size() == 0) begin
				$display("%0t: unexpected result, actual %0d", $time, res.escape_count);
				errors++;
			end else begin
				if (res.escape_count !== expected_counts[0]) begin
					$display("%0t: escape_count mismatch, expected %0d actual %0d",
						$time, expected_counts[0], res.escape_count);
					errors++;
				end
				void'(expected_counts.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((pnt.valid && pnt.ready) || (res.valid && res.ready) ||
			(cfg.valid && cfg.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// The point stays offered after its transfer; drain() withdraws it.
	task automatic send_point(efti_tb_pkg::point_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			pnt.valid <= 1'b0;
			@(posedge clk);
		end
		pnt.valid <= 1'b1;
		pnt.point_real <= p.re;
		pnt.point_imag <= p.im;
		expected_counts.push_back(escape_count_of(p));
		do @(posedge clk); while (!pnt.ready);
	endtask

	task automatic drain();
		pnt.valid <= 1'b0;
		while (expected_counts.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [31:0] val);
		drain();
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			efti_pkg::RegFractalMode:    mdl_mode = {7'd0, val[0]};
			efti_pkg::RegJuliaCReal:     mdl_cr = val;
			efti_pkg::RegJuliaCImag:     mdl_ci = val;
			efti_pkg::RegIterationLimit: mdl_limit = val[7:0];
			default: ;
		endcase
	endtask

	function automatic efti_tb_pkg::point_t pick_point();
		efti_tb_pkg::point_t p;
		case ($urandom_range(3))
			0: begin p.re = $urandom; p.im = $urandom; end
			default: begin
				p.re = $signed($urandom_range(32'h4000_0000)) - 32'sh2000_0000;
				p.im = $signed($urandom_range(32'h3000_0000)) - 32'sh1800_0000;
			end
		endcase
		return p;
	endfunction

	task automatic test_directed();
		efti_tb_pkg::point_t p;
		logic signed [31:0] v[8] = '{32'sh0, 32'sh7fffffff, 32'sh80000000, 32'sh1000_0000,
			-32'sh1000_0000, 32'sh2000_0000, -32'sh2000_0000, 32'sh0400_0000};
		for (int i = 0; i < 8; i++) begin
			p.re = v[i]; p.im = v[7 - i]; send_point(p);
		end
		p.re = -32'sh0c00_0000; p.im = 32'sh0; send_point(p);
		write_reg(efti_pkg::RegIterationLimit, 32'd0);
		p.re = 32'sh7fffffff; p.im = 32'sh7fffffff; send_point(p);
		write_reg(efti_pkg::RegIterationLimit, 32'd1);
		p.re = 32'sh0; p.im = 32'sh0; send_point(p);
		p.re = 32'sh1800_0000; p.im = 32'sh0; send_point(p);
		write_reg(8'd9, 32'hffffffff);
		write_reg(efti_pkg::RegIterationLimit, 32'd255);
		write_reg(efti_pkg::RegFractalMode, 32'd1);
		write_reg(efti_pkg::RegJuliaCReal, 32'h80000000);
		write_reg(efti_pkg::RegJuliaCImag, 32'h7fffffff);
		p.re = 32'sh0; p.im = 32'sh0; send_point(p);
		write_reg(efti_pkg::RegJuliaCReal, -32'sh0c00_0000);
		write_reg(efti_pkg::RegJuliaCImag, 32'sh0);
		p.re = 32'sh0; p.im = 32'sh0; send_point(p);
		write_reg(efti_pkg::RegFractalMode, 32'd0);
	endtask

	task automatic test_random(int n, int idle, int stall, int limit, bit julia);
		write_reg(efti_pkg::RegIterationLimit, 32'(limit));
		write_reg(efti_pkg::RegFractalMode, 32'(julia));
		write_reg(efti_pkg::RegJuliaCReal,
			$signed($urandom_range(32'h2000_0000)) - 32'sh1000_0000);
		write_reg(efti_pkg::RegJuliaCImag,
			$signed($urandom_range(32'h2000_0000)) - 32'sh1000_0000);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < n; i++) send_point(pick_point());
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	task automatic test_backpressure();
		drain();
		hold_req = hold_req + 1;
		for (int i = 0; i < 12; i++) send_point(pick_point());
		drain();
	endtask

	initial begin
		pnt.valid = 1'b0; pnt.point_real = '0; pnt.point_imag = '0;
		cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
		mdl_mode = '0; mdl_cr = '0; mdl_ci = '0; mdl_limit = efti_pkg::LimitReset;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(300, 0, 0, 64, 1'b0);
		test_random(300, 67, 0, 32, 1'b1);
		test_random(300, 0, 67, 255, 1'b0);
		test_random(300, 13, 13, 16, 1'b1);
		test_backpressure();
		test_random(80, 0, 0, 255, 1'b1);
		drain();
		repeat (1100) @(posedge clk);
		if (errors == 0 && expected_counts.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
